@@ rtl/sn_pkg.sv @@
// Shared types and fixed widths for the surface normal pipeline.
// Depends on nothing; every other file imports it.
`default_nettype none
package sn_pkg;
  localparam int FIELD_W = 16;
  localparam int EDGE_W = 17;
  localparam int PROD_W = 34;
  localparam int CROSS_W = 35;
  localparam int NMAG_W = 31;
  localparam int SQ_W = 62;
  localparam int SUM_W = 64;
  localparam int ROOT_W = 32;
  localparam int ROOT_STEPS = 32;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [2:0][CROSS_W-1:0] mag3_t;
  typedef logic [2:0][NMAG_W-1:0] nmag3_t;

  typedef struct packed {
    logic flat;
    logic deg;
    logic [2:0] neg;
  } side_t;
endpackage
`default_nettype wire

@@ rtl/sn_front.sv @@
// Front end: sign extension, edge vectors, cross product and its largest magnitude.
// Depends on sn_pkg. Four register stages.
`default_nettype none
module sn_front #(
  parameter int EFF_W = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic vld,
  input  wire sn_pkg::field_t base_x,
  input  wire sn_pkg::field_t base_y,
  input  wire sn_pkg::field_t base_z,
  input  wire sn_pkg::field_t first_x,
  input  wire sn_pkg::field_t first_y,
  input  wire sn_pkg::field_t first_z,
  input  wire sn_pkg::field_t second_x,
  input  wire sn_pkg::field_t second_y,
  input  wire sn_pkg::field_t second_z,
  output logic res_vld,
  output sn_pkg::mag3_t mag,
  output logic [sn_pkg::CROSS_W-1:0] mmax,
  output sn_pkg::side_t side
);
  import sn_pkg::*;

  function automatic logic signed [FIELD_W-1:0] sx(field_t v);
    sx = $signed(v << (FIELD_W - EFF_W)) >>> (FIELD_W - EFF_W);
  endfunction

  function automatic logic signed [EDGE_W-1:0] sub(field_t a, field_t b);
    logic signed [FIELD_W-1:0] sa;
    logic signed [FIELD_W-1:0] sb;
    sa = sx(a);
    sb = sx(b);
    sub = {sa[FIELD_W-1], sa} - {sb[FIELD_W-1], sb};
  endfunction

  logic [3:0] v;
  logic flat1, flat2, flat3;
  logic signed [EDGE_W-1:0] e1 [3];
  logic signed [EDGE_W-1:0] e2 [3];
  logic signed [PROD_W-1:0] pr [6];
  logic signed [CROSS_W-1:0] c [3];
  mag3_t mag3;
  logic [2:0] neg3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c[i] = {pr[2*i][PROD_W-1], pr[2*i]} - {pr[2*i+1][PROD_W-1], pr[2*i+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], vld};
    end
  end

  always_ff @(posedge clk) begin
    flat1 <= (sx(base_y) == '0);
    e1[0] <= sub(first_x, base_x);
    e1[1] <= sub(first_y, base_y);
    e1[2] <= sub(first_z, base_z);
    e2[0] <= sub(second_x, base_x);
    e2[1] <= sub(second_y, base_y);
    e2[2] <= sub(second_z, base_z);

    flat2 <= flat1;
    pr[0] <= e1[1] * e2[2];
    pr[1] <= e1[2] * e2[1];
    pr[2] <= e1[2] * e2[0];
    pr[3] <= e1[0] * e2[2];
    pr[4] <= e1[0] * e2[1];
    pr[5] <= e1[1] * e2[0];

    flat3 <= flat2;
    for (int i = 0; i < 3; i++) begin
      neg3[i] <= c[i][CROSS_W-1];
      mag3[i] <= c[i][CROSS_W-1] ? CROSS_W'(-c[i]) : CROSS_W'(c[i]);
    end

    mag <= mag3;
    mmax <= (mag3[0] > mag3[1]) ? ((mag3[0] > mag3[2]) ? mag3[0] : mag3[2])
                                : ((mag3[1] > mag3[2]) ? mag3[1] : mag3[2]);
    side.flat <= flat3;
    side.deg <= (mag3 == '0);
    side.neg <= neg3;
  end

  assign res_vld = v[3];
endmodule
`default_nettype wire

@@ rtl/sn_norm.sv @@
// Normalizing shift of the cross magnitudes, then squares and their sum.
// Depends on sn_pkg. Eight register stages.
`default_nettype none
module sn_norm (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic vld,
  input  wire sn_pkg::mag3_t mag,
  input  wire logic [sn_pkg::CROSS_W-1:0] mmax,
  input  wire sn_pkg::side_t side,
  output logic res_vld,
  output logic [sn_pkg::SUM_W-1:0] sum,
  output sn_pkg::nmag3_t nmag,
  output sn_pkg::side_t res_side
);
  import sn_pkg::*;

  localparam int LSTEPS = 5;

  logic [LSTEPS+2:0] v;
  logic [NMAG_W-1:0] lm [LSTEPS+1];
  nmag3_t lmag [LSTEPS+1];
  nmag3_t sqmag;
  side_t sd [LSTEPS+2];
  logic [2:0][SQ_W-1:0] sq;
  logic [2:0] rs;

  always_comb begin
    if (mmax[CROSS_W-1]) begin
      rs = 3'd4;
    end else if (mmax[CROSS_W-2]) begin
      rs = 3'd3;
    end else if (mmax[CROSS_W-3]) begin
      rs = 3'd2;
    end else if (mmax[CROSS_W-4]) begin
      rs = 3'd1;
    end else begin
      rs = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[LSTEPS+1:0], vld};
    end
  end

  always_ff @(posedge clk) begin
    lm[0] <= NMAG_W'(mmax >> rs);
    for (int i = 0; i < 3; i++) begin
      lmag[0][i] <= NMAG_W'(mag[i] >> rs);
    end
    sd[0] <= side;
    for (int j = 0; j < LSTEPS; j++) begin
      if ((lm[j] >> (NMAG_W - (16 >> j))) == '0) begin
        lm[j+1] <= lm[j] << (16 >> j);
        for (int i = 0; i < 3; i++) begin
          lmag[j+1][i] <= lmag[j][i] << (16 >> j);
        end
      end else begin
        lm[j+1] <= lm[j];
        lmag[j+1] <= lmag[j];
      end
      sd[j+1] <= sd[j];
    end
    for (int i = 0; i < 3; i++) begin
      sq[i] <= lmag[LSTEPS][i] * lmag[LSTEPS][i];
    end
    sqmag <= lmag[LSTEPS];
    sd[LSTEPS+1] <= sd[LSTEPS];
    sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    nmag <= sqmag;
    res_side <= sd[LSTEPS+1];
  end

  assign res_vld = v[LSTEPS+2];
endmodule
`default_nettype wire

@@ rtl/sn_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on sn_pkg. Thirty-three register stages.
`default_nettype none
module sn_sqrt (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic vld,
  input  wire logic [sn_pkg::SUM_W-1:0] sum,
  input  wire sn_pkg::nmag3_t nmag,
  input  wire sn_pkg::side_t side,
  output logic res_vld,
  output logic [sn_pkg::ROOT_W-1:0] root,
  output sn_pkg::nmag3_t res_nmag,
  output sn_pkg::side_t res_side
);
  import sn_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] rt;
  } sq_t;

  function automatic sq_t sq_step(sq_t s, int k);
    logic [SUM_W-1:0] bitv;
    logic [SUM_W-1:0] trial;
    sq_t r;
    bitv = SUM_W'(1) << (2 * (ROOT_STEPS - 1 - k));
    trial = s.rt + bitv;
    if (s.rem >= trial) begin
      r.rem = s.rem - trial;
      r.rt = (s.rt >> 1) + bitv;
    end else begin
      r.rem = s.rem;
      r.rt = s.rt >> 1;
    end
    return r;
  endfunction

  logic [ROOT_STEPS:0] v;
  sq_t st [ROOT_STEPS+1];
  nmag3_t mg [ROOT_STEPS+1];
  side_t sd [ROOT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[ROOT_STEPS-1:0], vld};
    end
  end

  always_ff @(posedge clk) begin
    st[0].rem <= sum;
    st[0].rt <= '0;
    mg[0] <= nmag;
    sd[0] <= side;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      st[k+1] <= sq_step(st[k], k);
      mg[k+1] <= mg[k];
      sd[k+1] <= sd[k];
    end
  end

  assign res_vld = v[ROOT_STEPS];
  assign root = st[ROOT_STEPS].rt[ROOT_W-1:0];
  assign res_nmag = mg[ROOT_STEPS];
  assign res_side = sd[ROOT_STEPS];
endmodule
`default_nettype wire

@@ rtl/sn_div.sv @@
// Three-lane pipelined restoring divider that scales each magnitude by the root.
// Depends on sn_pkg. FRAC plus two register stages.
`default_nettype none
module sn_div #(
  parameter int FRAC = 14
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic vld,
  input  wire logic [sn_pkg::ROOT_W-1:0] root,
  input  wire sn_pkg::nmag3_t nmag,
  input  wire sn_pkg::side_t side,
  output logic res_vld,
  output logic [2:0][FRAC:0] quo,
  output sn_pkg::side_t res_side
);
  import sn_pkg::*;

  localparam int QW = FRAC + 1;
  localparam int DIVW = ROOT_W + FRAC + 1;

  logic [QW:0] v;
  logic [2:0][DIVW-1:0] rem [QW+1];
  logic [2:0][QW-1:0] q [QW+1];
  logic [ROOT_W-1:0] d [QW+1];
  side_t sd [QW+1];
  logic [DIVW-1:0] dsh [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      dsh[k] = DIVW'(d[k]) << (QW - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[QW-1:0], vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rem[0][i] <= (DIVW'(nmag[i]) << FRAC) + DIVW'(root >> 1);
    end
    q[0] <= '0;
    d[0] <= root;
    sd[0] <= side;
    for (int k = 0; k < QW; k++) begin
      for (int i = 0; i < 3; i++) begin
        if (rem[k][i] >= dsh[k]) begin
          rem[k+1][i] <= rem[k][i] - dsh[k];
          q[k+1][i] <= q[k][i] | (QW'(1) << (QW - 1 - k));
        end else begin
          rem[k+1][i] <= rem[k][i];
          q[k+1][i] <= q[k][i];
        end
      end
      d[k+1] <= d[k];
      sd[k+1] <= sd[k];
    end
  end

  assign res_vld = v[QW];
  assign quo = q[QW];
  assign res_side = sd[QW];
endmodule
`default_nettype wire

@@ rtl/surface_normal_unit.sv @@
// Top level of the surface normal unit: front end, normalizer, root, divider, output stage.
// Depends on sn_pkg, sn_front, sn_norm, sn_sqrt and sn_div.
//
// One item enters per clock whenever start is high and busy is low; busy is high only
// during reset and the cycle after it. Each result appears for one cycle with done high,
// in order; the pipeline never stalls, so the receiver must take every result as it comes.
// Each item passes the front end, the normalizer, the 33-stage square root, the
// NORMAL_FRAC_BITS + 2 stage divider and a registered output stage.
`default_nettype none
module surface_normal_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic busy,
  input  wire sn_pkg::field_t base_x,
  input  wire sn_pkg::field_t base_y,
  input  wire sn_pkg::field_t base_z,
  input  wire sn_pkg::field_t first_x,
  input  wire sn_pkg::field_t first_y,
  input  wire sn_pkg::field_t first_z,
  input  wire sn_pkg::field_t second_x,
  input  wire sn_pkg::field_t second_y,
  input  wire sn_pkg::field_t second_z,
  output logic done,
  output sn_pkg::field_t normal_x,
  output sn_pkg::field_t normal_y,
  output sn_pkg::field_t normal_z,
  output logic degenerate
);
  import sn_pkg::*;

  localparam int EFF_W = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
  localparam int F = NORMAL_FRAC_BITS;
  localparam int RW = (F + 2 > FIELD_W) ? F + 2 : FIELD_W;
  localparam int LAT = F + 48;

  logic f_vld, n_vld, s_vld, d_vld;
  mag3_t f_mag;
  logic [CROSS_W-1:0] f_max;
  side_t f_side, n_side, s_side, d_side;
  logic [SUM_W-1:0] n_sum;
  nmag3_t n_nmag, s_nmag;
  logic [ROOT_W-1:0] s_root;
  logic [2:0][F:0] d_quo;
  logic [F:0] one;
  logic [2:0][FIELD_W-1:0] res;

  sn_front #(.EFF_W(EFF_W)) u_front (
    .clk(clk), .rst(rst), .vld(start && !busy),
    .base_x(base_x), .base_y(base_y), .base_z(base_z),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .res_vld(f_vld), .mag(f_mag), .mmax(f_max), .side(f_side)
  );

  sn_norm u_norm (
    .clk(clk), .rst(rst), .vld(f_vld), .mag(f_mag), .mmax(f_max), .side(f_side),
    .res_vld(n_vld), .sum(n_sum), .nmag(n_nmag), .res_side(n_side)
  );

  sn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .vld(n_vld), .sum(n_sum), .nmag(n_nmag), .side(n_side),
    .res_vld(s_vld), .root(s_root), .res_nmag(s_nmag), .res_side(s_side)
  );

  sn_div #(.FRAC(F)) u_div (
    .clk(clk), .rst(rst), .vld(s_vld), .root(s_root), .nmag(s_nmag), .side(s_side),
    .res_vld(d_vld), .quo(d_quo), .res_side(d_side)
  );

  assign one = (F + 1)'(1) << F;

  always_comb begin
    logic [F:0] n;
    logic [RW-1:0] ext;
    for (int i = 0; i < 3; i++) begin
      n = (d_quo[i] > one) ? one : d_quo[i];
      ext = RW'(n);
      ext = d_side.neg[i] ? RW'(-ext) : ext;
      res[i] = ext[FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      done <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (d_side.flat) begin
      normal_x <= '0;
      normal_y <= FIELD_W'(RW'(one));
      normal_z <= '0;
      degenerate <= 1'b0;
    end else if (d_side.deg) begin
      normal_x <= '0;
      normal_y <= '0;
      normal_z <= '0;
      degenerate <= 1'b1;
    end else begin
      normal_x <= res[0];
      normal_y <= res[1];
      normal_z <= res[2];
      degenerate <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("Result missing after an accepted item.");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("Result without a matching item.");
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
    else $error("Degenerate result with a nonzero normal.");
  a_busy_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("Busy low right after reset.");
`endif
endmodule
`default_nettype wire

@@ bench/tb_surface_normal_unit.sv @@
// Self-checking testbench for surface_normal_unit: drives vertex triples, predicts unit normals.
// Depends on sn_pkg and the surface_normal_unit RTL; needs no files or arguments.
`timescale 1ns / 1ps
`default_nettype none
module tb_surface_normal_unit;
  import sn_pkg::*;

  localparam int FRAC = 14;
  localparam int LATENCY = FRAC + 48;

  typedef struct {
    logic signed [15:0] v[9];
  } tri_t;

  typedef struct {
    logic [15:0] nx, ny, nz;
    logic deg;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  field_t base_x = '0, base_y = '0, base_z = '0;
  field_t first_x = '0, first_y = '0, first_z = '0;
  field_t second_x = '0, second_y = '0, second_z = '0;
  logic done;
  field_t normal_x, normal_y, normal_z;
  logic degenerate;

  tri_t pending_tris[$];
  normal_t expected_normals[$];
  int errors = 0;
  bit stim_done = 0;
  int cyc = 0;

  surface_normal_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .base_x(base_x), .base_y(base_y), .base_z(base_z),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .done(done), .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .degenerate(degenerate)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] val);
    logic [63:0] root, bitv, rem;
    rem = val;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic normal_t face_normal(tri_t t);
    normal_t r;
    longint e1[3], e2[3], c[3];
    logic [63:0] mag[3], mx, sum, root, n, one;
    one = 64'd1 << FRAC;
    r.nx = 0; r.ny = 0; r.nz = 0; r.deg = 0;
    if (t.v[1] == 0) begin
      r.ny = one[15:0];
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(t.v[3+i]) - longint'(t.v[i]);
      e2[i] = longint'(t.v[6+i]) - longint'(t.v[i]);
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (c[i] < 0) ? -c[i] : c[i];
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      r.deg = 1;
      return r;
    end
    while (mx >= (64'd1 << 31)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    sum = 0;
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    root = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      n = ((mag[i] << FRAC) + (root >> 1)) / root;
      if (n > one) n = one;
      if (c[i] < 0) n = -n;
      if (i == 0) r.nx = n[15:0];
      else if (i == 1) r.ny = n[15:0];
      else r.nz = n[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_coord(int mode);
    logic [15:0] x;
    x = 16'($urandom);
    case (mode)
      0: return x;
      1: return 16'(x % 16'd9) - 16'd4;
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return (x >>> 6) ^ {16{x[15]}};
    endcase
  endfunction

  task automatic add_tri(input logic [15:0] a[9]);
    tri_t t;
    for (int i = 0; i < 9; i++) t.v[i] = a[i];
    pending_tris.push_back(t);
  endtask

  initial begin
    logic [15:0] a[9];
    int mode;
    // Directed part: extremes, flat base, degenerate and axis-aligned triangles.
    a = '{16'h1000, 16'h0000, 16'h0, 16'h2000, 16'h1, 16'h0, 16'h0, 16'h5, 16'h1000};
    add_tri(a);
    a = '{16'h0, 16'h1000, 16'h0, 16'h1000, 16'h1000, 16'h0, 16'h0, 16'h1000, 16'h1000};
    add_tri(a);
    a = '{16'h0, 16'h1000, 16'h0, 16'h0, 16'h1000, 16'h1000, 16'h1000, 16'h1000, 16'h0};
    add_tri(a);
    a = '{16'h5, 16'h5, 16'h5, 16'h5, 16'h5, 16'h5, 16'h9, 16'h9, 16'h9};
    add_tri(a);
    a = '{16'h0, 16'h1, 16'h0, 16'h1, 16'h2, 16'h3, 16'h2, 16'h3, 16'h4};
    add_tri(a);
    a = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
          16'h8000, 16'h7fff, 16'h7fff};
    add_tri(a);
    a = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
          16'h7fff, 16'h8000, 16'h7fff};
    add_tri(a);
    a = '{16'h7fff, 16'hffff, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
          16'h7fff, 16'h8000, 16'h8000};
    add_tri(a);
    a = '{16'h0, 16'h1, 16'h0, 16'h1, 16'h1, 16'h0, 16'h0, 16'h1, 16'h1};
    add_tri(a);
    a = '{16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'hffff, 16'h0, 16'hffff, 16'h0};
    add_tri(a);
    for (int k = 0; k < 1950; k++) begin
      mode = $urandom_range(0, 3);
      for (int i = 0; i < 9; i++) a[i] = rand_coord(mode);
      if ($urandom_range(0, 19) == 0) a[1] = 0;
      if ($urandom_range(0, 24) == 0) begin
        a[3] = a[0]; a[4] = a[1]; a[5] = a[2];
      end
      add_tri(a);
    end
  end

  // Driver: holds start and the fields until the item is taken.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == 1) rst <= 1'b0;
    if (!rst) begin
      if (start && !busy) expected_normals.push_back(face_normal(pending_tris.pop_front()));
      if ((!start || !busy) && !stim_done) begin
        if (pending_tris.size() == ((start && !busy) ? 1 : 0) && start && !busy
            && pending_tris.size() == 0) begin
          start <= 1'b0;
          stim_done <= 1'b1;
        end else if (pending_tris.size() == 0) begin
          start <= 1'b0;
          stim_done <= 1'b1;
        end else if (!(cyc > 600 && cyc < 1200) && $urandom_range(0, 99) < 16) begin
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          base_x <= pending_tris[0].v[0]; base_y <= pending_tris[0].v[1];
          base_z <= pending_tris[0].v[2];
          first_x <= pending_tris[0].v[3]; first_y <= pending_tris[0].v[4];
          first_z <= pending_tris[0].v[5];
          second_x <= pending_tris[0].v[6]; second_y <= pending_tris[0].v[7];
          second_z <= pending_tris[0].v[8];
        end
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest prediction.
  always @(posedge clk) begin
    normal_t e;
    if (!rst && done) begin
      if (expected_normals.size() == 0) begin
        $error("unexpected result: normal_x %h", normal_x);
        errors++;
      end else begin
        e = expected_normals.pop_front();
        if (normal_x !== e.nx) begin
          $error("normal_x expected %h actual %h", e.nx, normal_x); errors++;
        end
        if (normal_y !== e.ny) begin
          $error("normal_y expected %h actual %h", e.ny, normal_y); errors++;
        end
        if (normal_z !== e.nz) begin
          $error("normal_z expected %h actual %h", e.nz, normal_z); errors++;
        end
        if (degenerate !== e.deg) begin
          $error("degenerate expected %b actual %b", e.deg, degenerate); errors++;
        end
      end
    end
  end

  initial begin
    int guard;
    wait (stim_done);
    guard = 0;
    while (expected_normals.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("surface_normal_unit: match");
    end else begin
      $display("surface_normal_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("surface_normal_unit: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
rtl/sn_pkg.sv
rtl/sn_front.sv
rtl/sn_norm.sv
rtl/sn_sqrt.sv
rtl/sn_div.sv
rtl/surface_normal_unit.sv
bench/tb_surface_normal_unit.sv
